// ===== rtl/bcrw_pkg.sv =====
// ----------------------------------------------------------------------------
// bcrw_pkg: shared types and constants
// Command and status bundles, register indexes and the arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package bcrw_pkg;

  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CntW     = 17;
  localparam int unsigned TblLen   = 24;
  localparam int unsigned CordX0   = 652032874;

  localparam logic [CfgAddrW-1:0] REG_BOX_X = 2'd0;
  localparam logic [CfgAddrW-1:0] REG_BOX_Y = 2'd1;
  localparam logic [CfgAddrW-1:0] REG_BOX_Z = 2'd2;
  localparam logic [CfgAddrW-1:0] REG_CHAIN = 2'd3;

  localparam logic OP_STEP    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef struct packed {
    logic load;       // capture input item, start the math
    logic sqrt_step;  // one root iteration
    logic cord_step;  // one cordic iteration
    logic mul_x;      // s * cos phi
    logic mul_y;      // s * sin phi
    logic check;      // add and compare against box
    logic commit;     // update position and output
  } bcrw_cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic cord_done;
  } bcrw_sts_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bcrw_if.sv =====
// ----------------------------------------------------------------------------
// bcrw_in_if / bcrw_out_if: valid/ready channels
// Step items in, bead results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcrw_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] rand_polar;
  logic [15:0] rand_azimuth;
  modport source (output valid, op, rand_polar, rand_azimuth, input ready);
  modport sink   (input valid, op, rand_polar, rand_azimuth, output ready);
endinterface

interface bcrw_out_if;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic [16:0]        bead_number;
  logic               last_bead;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  modport source (output valid, accepted, bead_number, last_bead, pos_x, pos_y, pos_z,
                  input ready);
  modport sink   (input valid, accepted, bead_number, last_bead, pos_x, pos_y, pos_z,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/bcrw_ctrl.sv =====
// ----------------------------------------------------------------------------
// bcrw_ctrl: step sequencer
// Runs root, cordic, two products and the box check for one step item.
// ----------------------------------------------------------------------------
`default_nettype none

module bcrw_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              out_free,
  input  wire bcrw_pkg::bcrw_sts_t sts,
  output bcrw_pkg::bcrw_cmd_t    cmd,
  output logic                   busy
);
  import bcrw_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ITER = 3'd1;
  localparam logic [2:0] S_MULX = 3'd2;
  localparam logic [2:0] S_MULY = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_ITER;
        end
      end
      S_ITER: begin
        cmd.sqrt_step = !sts.sqrt_done;
        cmd.cord_step = !sts.cord_done;
        if (sts.sqrt_done && sts.cord_done) state_next = S_MULX;
      end
      S_MULX: begin
        cmd.mul_x  = 1'b1;
        state_next = S_MULY;
      end
      S_MULY: begin
        cmd.mul_y  = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        cmd.check  = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/bcrw_dp.sv =====
// ----------------------------------------------------------------------------
// bcrw_dp: step datapath
// Angle setup, bit-pair root, shared cordic, products and box check.
// ----------------------------------------------------------------------------
`default_nettype none

module bcrw_dp #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire bcrw_pkg::bcrw_cmd_t cmd,
  input  wire logic [15:0]       rand_polar,
  input  wire logic [15:0]       rand_azimuth,
  input  wire logic signed [31:0] cur_x,
  input  wire logic signed [31:0] cur_y,
  input  wire logic signed [31:0] cur_z,
  input  wire logic [31:0]       box_len_x,
  input  wire logic [31:0]       box_len_y,
  input  wire logic [31:0]       box_len_z,
  output bcrw_pkg::bcrw_sts_t    sts,
  output logic signed [31:0]     new_x,
  output logic signed [31:0]     new_y,
  output logic signed [31:0]     new_z,
  output logic                   fits
);
  import bcrw_pkg::*;

  localparam int unsigned Steps = (CORDIC_STEPS < TblLen) ? CORDIC_STEPS : TblLen;
  localparam int unsigned IterW = 5;

  // cos theta: c = 65536 - ceil-ish(2*rp*65536/65535); 2*rp*65536/65535
  // = 2*rp + 2*rp/65535; with +32767 rounding and rp<=65535 a single
  // correction step suffices
  logic [33:0] cnum;
  logic [17:0] cq;
  logic [33:0] cprod;
  logic [17:0] cq_fix;
  logic signed [17:0] c_val;
  logic [48:0] anum;
  logic [32:0] aq;
  logic [48:0] aprod;
  logic [32:0] aq_fix;

  always_comb begin
    cnum   = {1'b0, rand_polar, 17'd0} + 34'd32767;
    cq     = {1'b0, rand_polar, 1'b0} + 18'(cnum >> 32);
    cprod  = 34'(cq) * 34'd65535;
    cq_fix = (cnum - cprod >= 34'd65535) ? cq + 18'd1 : cq;
    c_val  = 18'sd65536 - signed'(cq_fix);
    // angle: ra*2^32/65535 = ra*65537 + ra*65537/... approximated then fixed
    anum   = {1'b0, rand_azimuth, 32'd0} + 49'd32767;
    aq     = 33'({rand_azimuth, 16'd0}) + 33'(rand_azimuth) + 33'(anum >> 48);
    aprod  = 49'(aq) * 49'd65535;
    aq_fix = (anum >= aprod + 49'd65535) ? aq + 33'd1 :
             (anum < aprod) ? aq - 33'd1 : aq;
  end

  // registers
  logic signed [17:0] c_r;
  logic [1:0]         quad;
  logic [33:0]        rad;    // remaining n for the root
  logic [33:0]        root;
  logic [33:0]        bitv;
  logic signed [33:0] cx, cy, cz;
  logic [IterW-1:0]   it;
  logic signed [49:0] px, py;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_r  <= c_val;
      quad <= aq_fix[31:30];
      rad  <= 34'h1_0000_0000 - 34'(c_val * c_val);
      root <= '0;
      bitv <= 34'h1_0000_0000;
      cx   <= 34'(CordX0);
      cy   <= '0;
      cz   <= signed'({4'd0, aq_fix[29:0]});
      it   <= '0;
    end
    if (cmd.sqrt_step) begin
      if (rad >= root + bitv) begin
        rad  <= rad - (root + bitv);
        root <= (root >> 1) + bitv;
      end else begin
        root <= root >> 1;
      end
      bitv <= bitv >> 2;
    end
    if (cmd.cord_step) begin
      if (!cz[33]) begin
        cx <= cx - (cy >>> it);
        cy <= cy + (cx >>> it);
        cz <= cz - signed'({2'b00, atan_turn(it)});
      end else begin
        cx <= cx + (cy >>> it);
        cy <= cy - (cx >>> it);
        cz <= cz + signed'({2'b00, atan_turn(it)});
      end
      it <= it + IterW'(1);
    end
  end

  assign sts.sqrt_done = (bitv == '0);
  assign sts.cord_done = (32'(it) >= Steps);

  // quadrant and rounding to q16.16
  logic signed [33:0] cs_raw, sn_raw;
  logic signed [19:0] cs16, sn16;
  always_comb begin
    unique case (quad)
      2'd0:    begin cs_raw = cx;  sn_raw = cy;  end
      2'd1:    begin cs_raw = -cy; sn_raw = cx;  end
      2'd2:    begin cs_raw = -cx; sn_raw = -cy; end
      default: begin cs_raw = cy;  sn_raw = -cx; end
    endcase
    cs16 = 20'((cs_raw + 34'sd8192) >>> 14);
    sn16 = 20'((sn_raw + 34'sd8192) >>> 14);
  end

  logic signed [18:0] s_sg;
  assign s_sg = signed'({1'b0, root[17:0]});

  always_ff @(posedge clk) begin
    if (cmd.mul_x) px <= 50'(s_sg * cs16) + 50'sd32768;
    if (cmd.mul_y) py <= 50'(s_sg * sn16) + 50'sd32768;
  end

  // proposal and box check
  logic signed [34:0] nx, ny, nz;
  logic [34:0] mx, my, mz;
  always_comb begin
    nx = 35'(cur_x) + 35'(px >>> 16);
    ny = 35'(cur_y) + 35'(py >>> 16);
    nz = 35'(cur_z) + 35'(c_r);
    mx = nx[34] ? 35'(-nx) : 35'(nx);
    my = ny[34] ? 35'(-ny) : 35'(ny);
    mz = nz[34] ? 35'(-nz) : 35'(nz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fits <= 1'b0;
    end else if (cmd.check) begin
      fits <= ({mx, 1'b0} <= 36'(box_len_x)) && ({my, 1'b0} <= 36'(box_len_y)) &&
              ({mz, 1'b0} <= 36'(box_len_z));
    end
    if (cmd.check) begin
      new_x <= nx[31:0];
      new_y <= ny[31:0];
      new_z <= nz[31:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/box_confined_random_walk_step.sv =====
// ----------------------------------------------------------------------------
// box_confined_random_walk_step: 3d unit-step random walk in a box
// Places beads of a chain one accepted step at a time.
// ----------------------------------------------------------------------------
//  channel  | dir | contents
//  in_ch    | in  | op, rand_polar, rand_azimuth
//  out_ch   | out | accepted, bead_number, last_bead, pos_x/y/z
//  cfg      | in  | cfg_we, cfg_addr, cfg_wdata (box lengths, chain length)
//
// after its transfer, a step that needs math runs 17 bit-pair root steps next to
// the shared cordic, a final pass of the loop state to leave the loop, two
// products, the box check and a commit that waits for a free output register
// the next item is taken in the cycle after the commit at the earliest
// restarts, full-chain and not-started steps reach the output register at their transfer
// a new item waits while a result is held, unless that result transfers;
// a stalled output holds the step sequencer in its last state
// ----------------------------------------------------------------------------
`default_nettype none

module box_confined_random_walk_step #(
  parameter int unsigned MAX_BEADS    = 65536,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  bcrw_in_if.sink                            in_ch,
  bcrw_out_if.source                         out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [bcrw_pkg::CfgAddrW-1:0] cfg_addr,
  input  wire logic [bcrw_pkg::CfgDataW-1:0] cfg_wdata
);
  import bcrw_pkg::*;

  localparam int unsigned CapVal = (MAX_BEADS > 131071) ? 131071 : MAX_BEADS;

  // configuration registers
  logic [31:0] box_len_x, box_len_y, box_len_z;
  logic [16:0] chain_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_len_x    <= 32'd1310720;
      box_len_y    <= 32'd1310720;
      box_len_z    <= 32'd1310720;
      chain_length <= 17'd1000;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_BOX_X: box_len_x    <= cfg_wdata;
        REG_BOX_Y: box_len_y    <= cfg_wdata;
        REG_BOX_Z: box_len_z    <= cfg_wdata;
        default:   chain_length <= cfg_wdata[16:0];
      endcase
    end
  end

  // effective chain length: zero reads as one, capped at the bead limit
  logic [16:0] eff_len;
  always_comb begin
    eff_len = (chain_length == '0) ? 17'd1 : chain_length;
    if (32'(eff_len) > CapVal) eff_len = 17'(CapVal);
  end

  // walker state
  logic signed [31:0] cur_x, cur_y, cur_z;
  logic [16:0]        beads;

  // output register
  logic out_valid;
  logic out_free;
  assign out_free     = !out_valid || out_ch.ready;
  assign out_ch.valid = out_valid;

  bcrw_cmd_t cmd;
  bcrw_sts_t sts;
  logic      busy;
  logic signed [31:0] new_x, new_y, new_z;
  logic      fits;

  // a step needs math only with a chain started and not full
  logic in_fire, needs_math, quick;
  assign in_ch.ready = !busy && out_free;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign needs_math  = (in_ch.op == OP_STEP) && (beads != '0) && (beads < eff_len);
  assign quick       = in_fire && !needs_math;

  bcrw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (in_fire && needs_math),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  bcrw_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .rand_polar   (in_ch.rand_polar),
    .rand_azimuth (in_ch.rand_azimuth),
    .cur_x        (cur_x),
    .cur_y        (cur_y),
    .cur_z        (cur_z),
    .box_len_x    (box_len_x),
    .box_len_y    (box_len_y),
    .box_len_z    (box_len_z),
    .sts          (sts),
    .new_x        (new_x),
    .new_y        (new_y),
    .new_z        (new_z),
    .fits         (fits)
  );

  // state after this transfer, shown on the output
  logic signed [31:0] nx, ny, nz;
  logic [16:0]        nb;
  logic               nacc;
  always_comb begin
    nx = cur_x; ny = cur_y; nz = cur_z; nb = beads; nacc = 1'b0;
    if (quick && in_ch.op == OP_RESTART) begin
      nx = '0; ny = '0; nz = '0; nb = 17'd1; nacc = 1'b1;
    end else if (cmd.commit && fits) begin
      nx = new_x; ny = new_y; nz = new_z; nb = beads + 17'd1; nacc = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x <= '0; cur_y <= '0; cur_z <= '0;
      beads <= '0;
      out_valid <= 1'b0;
    end else begin
      cur_x <= nx; cur_y <= ny; cur_z <= nz;
      beads <= nb;
      if (quick || cmd.commit) out_valid <= 1'b1;
      else if (out_ch.ready)   out_valid <= 1'b0;
    end
    if (quick || cmd.commit) begin
      out_ch.accepted    <= nacc;
      out_ch.bead_number <= nb;
      out_ch.last_bead   <= (nb != '0) && (nb >= eff_len);
      out_ch.pos_x       <= nx;
      out_ch.pos_y       <= ny;
      out_ch.pos_z       <= nz;
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb_box_confined_random_walk_step.sv =====
// ----------------------------------------------------------------------------
// tb_box_confined_random_walk_step: self-checking bench for the random walk
// Drives restart and step items in bursts, predicts every bead result in
// fixed point and compares it field by field against the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_box_confined_random_walk_step;
  import bcrw_pkg::*;

  typedef struct {
    logic        op;
    logic [15:0] polar;
    logic [15:0] azim;
  } step_item_t;

  typedef struct {
    logic               placed;
    logic [16:0]        bead_no;
    logic               full;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } bead_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;

  bcrw_in_if  in_ch();
  bcrw_out_if out_ch();

  box_confined_random_walk_step dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor copy of configuration and walker state
  logic [31:0] box_x, box_y, box_z;
  logic [16:0] chain_len;
  logic signed [31:0] walk_x, walk_y, walk_z;
  logic [16:0] beads_done;

  step_item_t   pending_items[$];
  bead_result_t expected_beads[$];
  int mismatches = 0;

  // own arctangent table, units of 2^-32 turn
  localparam logic [31:0] ATAN_TURN [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // sine and cosine of a turn fraction, rounded to q16.16
  function automatic void turn_trig(input logic [31:0] ang,
                                    output longint cs, output longint sn);
    longint x, y, z, t;
    x = 652032874;
    y = 0;
    z = longint'(ang[29:0]);
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= longint'(ATAN_TURN[i]);
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += longint'(ATAN_TURN[i]);
      end
      x = t;
    end
    case (ang[31:30])
      2'd0: begin cs = x;  sn = y;  end
      2'd1: begin cs = -y; sn = x;  end
      2'd2: begin cs = -x; sn = -y; end
      default: begin cs = y; sn = -x; end
    endcase
    cs = (cs + 8192) >>> 14;
    sn = (sn + 8192) >>> 14;
  endfunction

  function automatic bit within_box(longint p, logic [31:0] len);
    longint m;
    m = p < 0 ? -p : p;
    return (m * 2) <= longint'(len);
  endfunction

  // advance the walker by one item and return its bead result
  function automatic bead_result_t walk_one(step_item_t it);
    bead_result_t r;
    longint unsigned lenv, num;
    longint c, s, cp, sp, nx, ny, nz;
    logic [31:0] ang;
    lenv = (chain_len == 0) ? 1 : chain_len;
    if (lenv > 65536) lenv = 65536;
    r.placed = 1'b0;
    if (it.op == OP_RESTART) begin
      walk_x = '0; walk_y = '0; walk_z = '0;
      beads_done = 17'd1;
      r.placed = 1'b1;
    end else if (beads_done != 0 && beads_done < lenv) begin
      c = 65536 - longint'((64'd131072 * it.polar + 32767) / 65535);
      s = longint'(int_root((64'd1 << 32) - longint'(c * c)));
      num = ((64'(it.azim) << 32) + 32767) / 65535;
      ang = num[31:0];
      turn_trig(ang, cp, sp);
      nx = longint'(walk_x) + ((s * cp + 32768) >>> 16);
      ny = longint'(walk_y) + ((s * sp + 32768) >>> 16);
      nz = longint'(walk_z) + c;
      if (within_box(nx, box_x) && within_box(ny, box_y) && within_box(nz, box_z)) begin
        walk_x = nx[31:0]; walk_y = ny[31:0]; walk_z = nz[31:0];
        beads_done = beads_done + 17'd1;
        r.placed = 1'b1;
      end
    end
    r.bead_no = beads_done;
    r.full = (beads_done != 0 && beads_done >= lenv);
    r.px = walk_x; r.py = walk_y; r.pz = walk_z;
    return r;
  endfunction

  // ---------------- driver: bursts and gaps on the input side
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (!in_ch.valid || in_ch.ready) begin
        // current item gone (or none): predict and maybe offer the next one
        if (in_ch.valid) expected_beads.push_back(walk_one('{in_ch.op,
            in_ch.rand_polar, in_ch.rand_azimuth}));
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          step_item_t it;
          it = pending_items.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.op <= it.op;
          in_ch.rand_polar <= it.polar;
          in_ch.rand_azimuth <= it.azim;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor: stall pattern on the output side, checking
  int stall_phase = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      stall_phase <= (stall_phase + 1) % 64;
      // long open window, then a jittery stall region
      out_ch.ready <= (stall_phase < 24) ? 1'b1 : ($urandom_range(0, 2) != 0);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_beads.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer");
        end else begin
          bead_result_t e;
          e = expected_beads.pop_front();
          if (e.placed !== out_ch.accepted || e.bead_no !== out_ch.bead_number ||
              e.full !== out_ch.last_bead || e.px !== out_ch.pos_x ||
              e.py !== out_ch.pos_y || e.pz !== out_ch.pos_z) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"bead mismatch exp acc=%0d n=%0d last=%0d (%0d,%0d,%0d)",
                        " got acc=%0d n=%0d last=%0d (%0d,%0d,%0d)"},
                       e.placed, e.bead_no, e.full, e.px, e.py, e.pz,
                       out_ch.accepted, out_ch.bead_number, out_ch.last_bead,
                       out_ch.pos_x, out_ch.pos_y, out_ch.pos_z);
          end
        end
      end
    end
  end

  task automatic push_item(logic op, logic [15:0] p, logic [15:0] a);
    pending_items.push_back('{op, p, a});
  endtask

  // register write while idle, mirrored in the predictor
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BOX_X: box_x = val;
      REG_BOX_Y: box_y = val;
      REG_BOX_Z: box_z = val;
      REG_CHAIN: chain_len = val[16:0];
      default: ;
    endcase
  endtask

  // wait for every expected bead, then let the block settle
  task automatic drain();
    while (pending_items.size() != 0 || in_ch.valid || expected_beads.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // one phase of random walking: mostly steps, sometimes a restart
  task automatic walk_phase(int n);
    push_item(OP_RESTART, 16'($urandom), 16'($urandom));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 40) == 0)
        push_item(OP_RESTART, 16'($urandom), 16'($urandom));
      else
        push_item(OP_STEP, 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    in_ch.valid = 1'b0; in_ch.op = 1'b0;
    in_ch.rand_polar = '0; in_ch.rand_azimuth = '0;
    out_ch.ready = 1'b0;
    box_x = 32'd1310720; box_y = 32'd1310720; box_z = 32'd1310720;
    chain_len = 17'd1000;
    walk_x = '0; walk_y = '0; walk_z = '0; beads_done = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: step before any restart, field extremes, quadrants
    push_item(OP_STEP, 16'h1234, 16'h4321);
    push_item(OP_RESTART, 16'hFFFF, 16'hFFFF);
    push_item(OP_STEP, 16'h0000, 16'h0000);
    push_item(OP_STEP, 16'hFFFF, 16'hFFFF);
    push_item(OP_STEP, 16'h7FFF, 16'h0000);
    push_item(OP_STEP, 16'h8000, 16'h4000);
    push_item(OP_STEP, 16'h8000, 16'h8000);
    push_item(OP_STEP, 16'h8000, 16'hC000);
    push_item(OP_STEP, 16'h8000, 16'hFFFF);
    push_item(OP_STEP, 16'h5555, 16'hAAAA);
    push_item(OP_STEP, 16'hAAAA, 16'h5555);
    drain();

    // chain length 1: restart is full at once, steps rejected
    write_reg(REG_CHAIN, 32'd1);
    push_item(OP_RESTART, 16'h0, 16'h0);
    push_item(OP_STEP, 16'h8000, 16'h0);
    drain();
    // chain length 0 counts as 1
    write_reg(REG_CHAIN, 32'd0);
    push_item(OP_STEP, 16'h8000, 16'h0);
    push_item(OP_RESTART, 16'h0, 16'h0);
    drain();

    // tight box: z of a full step lies outside a zero box
    write_reg(REG_BOX_X, 32'd0);
    write_reg(REG_BOX_Y, 32'd0);
    write_reg(REG_BOX_Z, 32'd0);
    write_reg(REG_CHAIN, 32'd5);
    push_item(OP_RESTART, 16'h0, 16'h0);
    push_item(OP_STEP, 16'h0, 16'h0);
    push_item(OP_STEP, 16'h7FFF, 16'h0);
    drain();

    // short chain in a small box: fills up, then lowered mid-chain
    write_reg(REG_BOX_X, 32'd196608);
    write_reg(REG_BOX_Y, 32'd196608);
    write_reg(REG_BOX_Z, 32'd196608);
    write_reg(REG_CHAIN, 32'd12);
    walk_phase(150);
    drain();
    write_reg(REG_CHAIN, 32'd3);
    push_item(OP_STEP, 16'h4000, 16'h1000);
    drain();

    // default-like box, long chain
    write_reg(REG_BOX_X, 32'd1310720);
    write_reg(REG_BOX_Y, 32'd655360);
    write_reg(REG_BOX_Z, 32'd262144);
    write_reg(REG_CHAIN, 32'd65536);
    walk_phase(300);
    drain();

    // widest box and out-of-range chain length capped at the maximum
    write_reg(REG_BOX_X, 32'hFFFFFFFF);
    write_reg(REG_BOX_Y, 32'hFFFFFFFF);
    write_reg(REG_BOX_Z, 32'hFFFFFFFF);
    write_reg(REG_CHAIN, 32'h1FFFF);
    walk_phase(300);
    drain();

    // narrow random box, medium chain
    write_reg(REG_BOX_X, $urandom_range(65536, 400000));
    write_reg(REG_BOX_Y, $urandom_range(65536, 400000));
    write_reg(REG_BOX_Z, $urandom_range(131072, 400000));
    write_reg(REG_CHAIN, $urandom_range(20, 200));
    walk_phase(300);
    drain();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // generous limit: room for 1100 items and their stalls many times over
  initial begin
    #(12 * 2000000);
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
